// ===== rtl/core/bdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_pkg
// Operation codes, field widths and the pending-stage record of the bounded
// double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int CAP_W   = 11;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_NONE       = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    // what an accepted item leaves for the result stage
    typedef struct packed {
        logic ok;
        logic fix_front;   // new front comes from the memory read
        logic fix_rear;    // new rear comes from the memory read
        logic empty;
        logic full;
    } t_pend;

endpackage

// ===== rtl/core/bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque of signed 32-bit values with a programmable capacity.
// The result passes through the pending stage and then the output register, and waits
// longer while the output register is stalled.
// Throughput: one item per cycle while the output is not stalled; a pop reads the
// new end entry from the registered-read entry memory, forwarded to the next item.
// Reset (synchronous, active low): empty, indices zero, capacity 1024.
// Entry memory is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bdeq_pkg::OP_W-1:0]            i_op,
    input  logic signed [bdeq_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_ok,
    output logic signed [bdeq_pkg::VALUE_W-1:0]  o_front_value,
    output logic signed [bdeq_pkg::VALUE_W-1:0]  o_rear_value,
    output logic                                 o_is_empty,
    output logic                                 o_is_full
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
    localparam logic [AW-1:0]   LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

    logic [bdeq_pkg::CAP_W-1:0] r_capacity;
    logic [AW-1:0]              r_head, n_head;
    logic [AW-1:0]              r_tail, n_tail;
    logic [CW-1:0]              r_count, n_count;
    logic signed [bdeq_pkg::VALUE_W-1:0] r_front, n_front;
    logic signed [bdeq_pkg::VALUE_W-1:0] r_rear, n_rear;
    logic                       r_pend;
    bdeq_pkg::t_pend            r_p, n_p;

    logic                       acc, move;
    logic [CMPW-1:0]            eff_cap;
    logic                       full_now, empty_now;
    logic signed [bdeq_pkg::VALUE_W-1:0] eff_front, eff_rear;
    logic signed [bdeq_pkg::VALUE_W-1:0] rd_value;
    logic [bdeq_pkg::VALUE_W-1:0] mem_rdata;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    bdeq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (bdeq_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_value = $signed(mem_rdata);

    // result stage drains into the output register when it is free
    assign move       = r_pend && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !move;
    assign acc        = i_in_valid && !o_in_stall;

    assign eff_cap = (CMPW'(r_capacity) > DEPTH_CMP) ? DEPTH_CMP : CMPW'(r_capacity);
    assign full_now  = CMPW'(r_count) >= eff_cap;
    assign empty_now = (r_count == '0);

    // forward the entry read for the previous pop
    assign eff_front = (r_pend && r_p.fix_front) ? rd_value : r_front;
    assign eff_rear  = (r_pend && r_p.fix_rear)  ? rd_value : r_rear;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_front   = eff_front;
        n_rear    = eff_rear;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_tail;
        mem_raddr = f_inc(r_head);
        n_p       = '0;
        n_p.ok    = 1'b1;
        if (acc) begin
            case (i_op)
                bdeq_pkg::OP_PUSH_FRONT: begin
                    if (full_now) begin
                        n_p.ok = 1'b0;
                    end else begin
                        n_head    = f_dec(r_head);
                        mem_we    = 1'b1;
                        mem_waddr = f_dec(r_head);
                        n_count   = r_count + CW'(1);
                        n_front   = i_value;
                        if (empty_now) begin
                            n_rear = i_value;
                        end
                    end
                end
                bdeq_pkg::OP_PUSH_REAR: begin
                    if (full_now) begin
                        n_p.ok = 1'b0;
                    end else begin
                        n_tail    = f_inc(r_tail);
                        mem_we    = 1'b1;
                        mem_waddr = r_tail;
                        n_count   = r_count + CW'(1);
                        n_rear    = i_value;
                        if (empty_now) begin
                            n_front = i_value;
                        end
                    end
                end
                bdeq_pkg::OP_POP_FRONT: begin
                    if (empty_now) begin
                        n_p.ok = 1'b0;
                    end else begin
                        n_head  = f_inc(r_head);
                        n_count = r_count - CW'(1);
                        // a single remaining entry is both ends: no read
                        if (r_count != CW'(1)) begin
                            mem_re        = 1'b1;
                            mem_raddr     = f_inc(r_head);
                            n_p.fix_front = 1'b1;
                        end
                    end
                end
                bdeq_pkg::OP_POP_REAR: begin
                    if (empty_now) begin
                        n_p.ok = 1'b0;
                    end else begin
                        n_tail  = f_dec(r_tail);
                        n_count = r_count - CW'(1);
                        if (r_count != CW'(1)) begin
                            mem_re       = 1'b1;
                            mem_raddr    = f_dec(f_dec(r_tail));
                            n_p.fix_rear = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_p.empty = (n_count == '0);
        n_p.full  = CMPW'(n_count) >= eff_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= bdeq_pkg::CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_p         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_p     <= n_p;
                r_pend  <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
                r_p    <= '0;
            end
            if (move) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_rear  <= n_rear;
        if (move) begin
            o_ok          <= r_p.ok;
            o_is_empty    <= r_p.empty;
            o_is_full     <= r_p.full;
            o_front_value <= r_p.empty ? bdeq_pkg::EMPTY_VALUE : eff_front;
            o_rear_value  <= r_p.empty ? bdeq_pkg::EMPTY_VALUE : eff_rear;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= DEPTH_CMP)
        else $error("entry count above depth");

    a_empty_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_pend)
        else $error("accepted item left no pending result");

    a_single_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !(r_p.fix_front && r_p.fix_rear))
        else $error("both ends marked for memory read");

endmodule

// ===== rtl/core/bdeq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_ram
// Entry store: one write port and one read port, registered read data that
// holds until the next read.
// ----------------------------------------------------------------------------
module bdeq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels and the capacity port of the deque. It keeps its own
// ring-buffer copy of the deque and predicts the snapshot of every accepted
// item, then compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [bdeq_pkg::OP_W-1:0]            i_op,
    input  logic signed [bdeq_pkg::VALUE_W-1:0]  i_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_ok,
    input  logic signed [bdeq_pkg::VALUE_W-1:0]  i_front_value,
    input  logic signed [bdeq_pkg::VALUE_W-1:0]  i_rear_value,
    input  logic                                 i_is_empty,
    input  logic                                 i_is_full,
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_results
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VALUE_W = bdeq_pkg::VALUE_W;
    localparam int OP_W    = bdeq_pkg::OP_W;
    localparam int CAP_W   = bdeq_pkg::CAP_W;

    // deque state as seen after one operation
    typedef struct packed {
        logic                       ok;
        logic signed [VALUE_W-1:0]  front;
        logic signed [VALUE_W-1:0]  rear;
        logic                       empty;
        logic                       full;
    } t_view;

    logic signed [VALUE_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]          head;
    logic [IDX_W-1:0]          tail;
    logic [CAP_W-1:0]          fill;
    logic [CAP_W-1:0]          capacity;
    t_view                     due_views [$];
    int                        mismatches = 0;
    int                        results = 0;

    assign o_mismatches = mismatches;
    assign o_results    = results;

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    // capacity above the ring size saturates
    function automatic int cap_limit();
        return (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    endfunction

    function automatic t_view step_deque(input logic [OP_W-1:0] op,
                                         input logic signed [VALUE_W-1:0] value);
        t_view v;
        logic  full;
        logic  empty;
        full  = int'(fill) >= cap_limit();
        empty = fill == '0;
        v.ok  = 1'b1;
        case (op)
            bdeq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    v.ok = 1'b0;
                end else begin
                    head = idx_down(head);
                    slots[head] = value;
                    fill = fill + CAP_W'(1);
                end
            end
            bdeq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    v.ok = 1'b0;
                end else begin
                    slots[tail] = value;
                    tail = idx_up(tail);
                    fill = fill + CAP_W'(1);
                end
            end
            bdeq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    v.ok = 1'b0;
                end else begin
                    head = idx_up(head);
                    fill = fill - CAP_W'(1);
                end
            end
            bdeq_pkg::OP_POP_REAR: begin
                if (empty) begin
                    v.ok = 1'b0;
                end else begin
                    tail = idx_down(tail);
                    fill = fill - CAP_W'(1);
                end
            end
            default: ;  // none and the unused codes
        endcase
        v.empty = fill == '0;
        v.full  = int'(fill) >= cap_limit();
        if (v.empty) begin
            v.front = bdeq_pkg::EMPTY_VALUE;
            v.rear  = bdeq_pkg::EMPTY_VALUE;
        end else begin
            v.front = slots[head];
            v.rear  = slots[idx_down(tail)];
        end
        return v;
    endfunction

    task automatic check_field(input string name, input logic signed [VALUE_W-1:0] want,
                               input logic signed [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_view want;
        if (!i_rst_n) begin
            head     = '0;
            tail     = '0;
            fill     = '0;
            capacity = bdeq_pkg::CAP_RESET;
            due_views.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (due_views.size() == 0) begin
                    $error("result arrived with no item pending");
                    mismatches++;
                end else begin
                    want = due_views.pop_front();
                    check_field("ok", want.ok, i_ok);
                    check_field("front_value", want.front, i_front_value);
                    check_field("rear_value", want.rear, i_rear_value);
                    check_field("is_empty", want.empty, i_is_empty);
                    check_field("is_full", want.full, i_is_full);
                end
            end
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                due_views.push_back(step_deque(i_op, i_value));
            end
        end
        o_outstanding <= due_views.size();
    end

endmodule

// ===== bench/tb_bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue
// Drives push, pop and idle operations into the deque under a range of
// capacities, including zero, one and values past the ring size, with
// random sender gaps and receiver stalls. Checking is done by deque_checker.
// ----------------------------------------------------------------------------
module tb_bounded_double_ended_queue;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 9;
    localparam int VALUE_W     = bdeq_pkg::VALUE_W;
    localparam int OP_W        = bdeq_pkg::OP_W;
    localparam int CAP_W       = bdeq_pkg::CAP_W;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]          i_cfg_wdata = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_op        = bdeq_pkg::OP_NONE;
    logic signed [VALUE_W-1:0] i_value     = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_ok;
    logic signed [VALUE_W-1:0] o_front_value;
    logic signed [VALUE_W-1:0] o_rear_value;
    logic                      o_is_empty;
    logic                      o_is_full;

    int mismatches;
    int outstanding;
    int results;
    int cycles      = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int cap_writes  = 0;

    // capacity, item count, sender idle %, receiver stall %, push share % per phase
    int phase_cap   [PHASES] = '{3, 1, 7, 2, 1024, 16, 2047, 0, 5};
    int phase_items [PHASES] = '{60, 40, 80, 40, 120, 100, 80, 20, 60};
    int phase_idle  [PHASES] = '{0, 49, 0, 18, 49, 0, 18, 0, 0};
    int phase_stall [PHASES] = '{0, 0, 49, 18, 0, 49, 18, 0, 0};
    int phase_push  [PHASES] = '{50, 50, 60, 40, 65, 55, 45, 50, 55};

    bounded_double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    deque_checker #(
        .DEPTH(DEPTH)
    ) deque_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_ok          (o_ok),
        .i_front_value (o_front_value),
        .i_rear_value  (o_rear_value),
        .i_is_empty    (o_is_empty),
        .i_is_full     (o_is_full),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL bounded_double_ended_queue");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // hold off the sender until every pending result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CAP_W'(cap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
        @(posedge i_clk);
    endtask

    task automatic random_item(input int push_pct);
        int                        r;
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        r = $urandom_range(99);
        if (r < 4) begin
            op = OP_W'($urandom_range(7, 4));  // none or an unused code
        end else if (r < 4 + push_pct) begin
            op = $urandom_range(1) ? bdeq_pkg::OP_PUSH_FRONT : bdeq_pkg::OP_PUSH_REAR;
        end else begin
            op = $urandom_range(1) ? bdeq_pkg::OP_POP_FRONT : bdeq_pkg::OP_POP_REAR;
        end
        case ($urandom_range(15))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2:       value = -32'sd1;
            3:       value = '0;
            default: value = $urandom();
        endcase
        send_item(op, value);
    endtask

    initial begin : stimulus
        int p;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, the idle codes, extremes pushed at both ends
        send_item(bdeq_pkg::OP_POP_FRONT, 32'sd11);
        send_item(bdeq_pkg::OP_POP_REAR, 32'sd12);
        send_item(bdeq_pkg::OP_NONE, 32'sd13);
        send_item(OP_W'(5), 32'sd14);
        send_item(OP_W'(6), 32'sd15);
        send_item(OP_W'(7), 32'sd16);
        send_item(bdeq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_item(bdeq_pkg::OP_PUSH_REAR, 32'sh7fff_ffff);
        send_item(bdeq_pkg::OP_PUSH_FRONT, -32'sd1);
        send_item(bdeq_pkg::OP_PUSH_REAR, 32'sd0);

        // capacity lowered below the four held entries
        write_capacity(2);
        send_item(bdeq_pkg::OP_PUSH_REAR, 32'sd21);
        send_item(bdeq_pkg::OP_POP_FRONT, 32'sd0);
        send_item(bdeq_pkg::OP_POP_REAR, 32'sd0);
        send_item(bdeq_pkg::OP_PUSH_FRONT, 32'sd22);
        send_item(bdeq_pkg::OP_POP_REAR, 32'sd0);

        // zero capacity refuses every push
        write_capacity(0);
        send_item(bdeq_pkg::OP_PUSH_FRONT, 32'sd31);
        send_item(bdeq_pkg::OP_PUSH_REAR, 32'sd32);
        send_item(bdeq_pkg::OP_POP_FRONT, 32'sd0);
        send_item(bdeq_pkg::OP_POP_REAR, 32'sd0);
        send_item(bdeq_pkg::OP_POP_REAR, 32'sd0);

        // all-ones capacity saturates at the ring size
        write_capacity(2047);
        send_item(bdeq_pkg::OP_PUSH_REAR, $urandom());
        send_item(bdeq_pkg::OP_PUSH_FRONT, $urandom());

        for (p = 0; p < PHASES; p++) begin
            write_capacity(phase_cap[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (n = 0; n < phase_items[p]; n++) begin
                random_item(phase_push[p]);
            end
            idle_pct  = 0;
            stall_pct = 0;
        end

        settle();
        $display("sent %0d items across %0d capacity settings, %0d results checked",
                 items_sent, cap_writes, results);
        $display("phases ran with no idling, sender gaps, receiver stalls and both");
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS bounded_double_ended_queue");
        end else begin
            $display("FAIL bounded_double_ended_queue");
        end
        $finish;
    end

endmodule
